[src/swsfd_pkg.sv]
// Shared constants, codes and types for the single-wire sensor frame decoder.
package swsfd_pkg;

    localparam int FRAME_BYTES_DEF = 5;

    localparam int MAX_W   = 10;
    localparam int THR_W   = 10;
    localparam int LEAD_W  = 4;
    localparam int FRAME_W = 7;
    localparam int WIDTH_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int STATUS_W = 2;
    localparam int BYTE_W = 8;

    localparam logic [MAX_W-1:0]   MAX_PULSE_RST = 10'd255;
    localparam logic [THR_W-1:0]   ONE_THR_RST   = 10'd28;
    localparam logic [LEAD_W-1:0]  LEAD_RST      = 4'd3;
    localparam logic [FRAME_W-1:0] FRAME_RST     = 7'd83;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME     = 2'd3;

    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_WIDTH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISMATCH   = 2'd3;

    // Event handed from the decoder to the output stage.
    typedef struct packed {
        logic                is_frame;
        logic [STATUS_W-1:0] err_status;
    } t_event;

    localparam int EVENT_W = $bits(t_event);

endpackage

[src/single_wire_sensor_frame_decoder_core.sv]
// Top level of the single-wire sensor frame decoder.
// Decodes a temperature and humidity sensor frame from one line sample per
// transaction. A start transaction arms capture; each sample transaction then
// measures pulse widths, turns high pulses after the lead-in into data bits
// and, at the configured pulse count, checks the checksum. One transaction is
// accepted every clock cycle whenever the two-entry event queue between the
// pulse decoder and the output register has room, so the sustained rate is one
// sample per cycle while results are taken. A result is registered in the event
// queue when the sample that causes it is accepted, and moves on into the output
// register once that register is empty or its result is being taken. Configuration
// writes take effect at the next edge and should be made while no frame is being
// captured. There is no clearing pass after reset.
module single_wire_sensor_frame_decoder_core #(
    parameter int FRAME_BYTES = swsfd_pkg::FRAME_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [swsfd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [swsfd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_req_type,
    input  logic                              i_pin_level,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [swsfd_pkg::STATUS_W-1:0]    o_status,
    output logic [swsfd_pkg::BYTE_W-1:0]      o_humidity_whole,
    output logic [swsfd_pkg::BYTE_W-1:0]      o_humidity_fraction,
    output logic [swsfd_pkg::BYTE_W-1:0]      o_temperature_whole,
    output logic [swsfd_pkg::BYTE_W-1:0]      o_temperature_fraction,
    output logic [swsfd_pkg::BYTE_W-1:0]      o_checksum_byte
);
    import swsfd_pkg::*;

    localparam int FB_BITS = FRAME_BYTES * 8;
    localparam int QW = EVENT_W + FB_BITS;

    logic               q_full;
    logic               q_nonempty;
    logic               q_push;
    logic               q_pop;
    t_event             push_event;
    logic [FB_BITS-1:0] push_bits;
    logic [QW-1:0]      q_head;
    t_event             head_event;
    logic [FB_BITS-1:0] head_bits;

    swsfd_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_pin_level(i_pin_level),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_event    (push_event),
        .o_bits     (push_bits)
    );

    swsfd_queue #(
        .W(QW)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (q_push),
        .i_data    ({push_event, push_bits}),
        .o_full    (q_full),
        .o_nonempty(q_nonempty),
        .i_pop     (q_pop),
        .o_data    (q_head)
    );

    assign head_event = t_event'(q_head[QW-1:FB_BITS]);
    assign head_bits  = q_head[FB_BITS-1:0];

    swsfd_back #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_q_nonempty          (q_nonempty),
        .o_q_pop               (q_pop),
        .i_event               (head_event),
        .i_bits                (head_bits),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_status              (o_status),
        .o_humidity_whole      (o_humidity_whole),
        .o_humidity_fraction   (o_humidity_fraction),
        .o_temperature_whole   (o_temperature_whole),
        .o_temperature_fraction(o_temperature_fraction),
        .o_checksum_byte       (o_checksum_byte)
    );

    // Only an accepted sample can create an event.
    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (i_valid && o_ready && (i_req_type == REQ_SAMPLE)))
        else $error("event pushed without an accepted sample");

endmodule

[src/swsfd_front.sv]
// Pulse-width decoder: configuration registers, capture state and bit assembly.
module swsfd_front #(
    parameter int FRAME_BYTES = swsfd_pkg::FRAME_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [swsfd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [swsfd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_req_type,
    input  logic                              i_pin_level,
    input  logic                              i_q_full,
    output logic                              o_push,
    output swsfd_pkg::t_event                 o_event,
    output logic [FRAME_BYTES*8-1:0]          o_bits
);
    import swsfd_pkg::*;

    localparam int FB_BITS = FRAME_BYTES * 8;
    localparam int BCW = $clog2(FB_BITS + 1);
    localparam int KW = BCW - 3;

    logic [MAX_W-1:0]   r_max_pulse;
    logic [THR_W-1:0]   r_one_thr;
    logic [LEAD_W-1:0]  r_lead;
    logic [FRAME_W-1:0] r_frame_pulses;

    logic               r_capturing, n_capturing;
    logic               r_level, n_level;
    logic [WIDTH_W-1:0] r_width, n_width;
    logic [FRAME_W-1:0] r_pulse, n_pulse;
    logic [BCW-1:0]     r_bit_cnt, n_bit_cnt;
    logic [FB_BITS-1:0] r_frame, n_frame;

    logic               accept;
    logic [WIDTH_W-1:0] width_inc;
    logic [FRAME_W-1:0] pulse_inc;
    logic               take_bit;
    logic               data_bit;
    logic [FB_BITS-1:0] frame_put;
    logic               room;

    assign o_ready   = !i_q_full;
    assign accept    = i_valid && o_ready;
    assign width_inc = r_width + WIDTH_W'(1);
    assign pulse_inc = r_pulse + FRAME_W'(1);
    // The ending pulse was high when the new sample is low.
    assign take_bit  = (r_pulse >= FRAME_W'(r_lead)) && !i_pin_level;
    assign data_bit  = r_width > WIDTH_W'(r_one_thr);
    assign room      = r_bit_cnt < BCW'(FB_BITS);

    always_comb begin
        frame_put = r_frame;
        for (int j = 0; j < FRAME_BYTES; j++) begin
            if (room && (r_bit_cnt[BCW-1:3] == KW'(j))) begin
                frame_put[j*8 +: 8] = {r_frame[j*8 +: 7], data_bit};
            end
        end
    end

    always_comb begin
        n_capturing = r_capturing;
        n_level     = r_level;
        n_width     = r_width;
        n_pulse     = r_pulse;
        n_bit_cnt   = r_bit_cnt;
        n_frame     = r_frame;
        o_push      = 1'b0;
        o_event     = '{is_frame: 1'b0, err_status: ST_TIMEOUT};
        o_bits      = '0;
        if (accept) begin
            if (i_req_type == REQ_START) begin
                n_capturing = 1'b1;
                n_level     = i_pin_level;
                n_width     = '0;
                n_pulse     = '0;
                n_bit_cnt   = '0;
                n_frame     = '0;
            end else if (r_capturing) begin
                if (i_pin_level == r_level) begin
                    n_width = width_inc;
                    if (width_inc > WIDTH_W'(r_max_pulse)) begin
                        n_capturing = 1'b0;
                        o_push      = 1'b1;
                    end
                end else if (r_width == '0) begin
                    n_capturing = 1'b0;
                    o_push      = 1'b1;
                    o_event     = '{is_frame: 1'b0, err_status: ST_ZERO_WIDTH};
                end else begin
                    n_level = i_pin_level;
                    n_pulse = pulse_inc;
                    if (take_bit) begin
                        n_frame = frame_put;
                        if (room) begin
                            n_bit_cnt = r_bit_cnt + BCW'(1);
                        end
                    end
                    if ((pulse_inc >= r_frame_pulses) || (pulse_inc == '0)) begin
                        n_capturing = 1'b0;
                        o_push      = 1'b1;
                        o_event     = '{is_frame: 1'b1, err_status: ST_OK};
                        o_bits      = take_bit ? frame_put : r_frame;
                    end else begin
                        n_width = WIDTH_W'(1);
                        if (r_max_pulse == '0) begin
                            n_capturing = 1'b0;
                            o_push      = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pulse    <= MAX_PULSE_RST;
            r_one_thr      <= ONE_THR_RST;
            r_lead         <= LEAD_RST;
            r_frame_pulses <= FRAME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_PULSE: r_max_pulse    <= i_cfg_data[MAX_W-1:0];
                CFG_ONE_THR:   r_one_thr      <= i_cfg_data[THR_W-1:0];
                CFG_LEAD:      r_lead         <= i_cfg_data[LEAD_W-1:0];
                CFG_FRAME:     r_frame_pulses <= i_cfg_data[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capturing <= 1'b0;
            r_level     <= 1'b1;
            r_width     <= '0;
            r_pulse     <= '0;
            r_bit_cnt   <= '0;
            r_frame     <= '0;
        end else begin
            r_capturing <= n_capturing;
            r_level     <= n_level;
            r_width     <= n_width;
            r_pulse     <= n_pulse;
            r_bit_cnt   <= n_bit_cnt;
            r_frame     <= n_frame;
        end
    end

    // Every reported event ends the capture.
    a_push_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> !r_capturing)
        else $error("capture still armed after a reported event");

    // The bit counter never runs past the frame buffer.
    a_bit_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt <= BCW'(FB_BITS))
        else $error("bit counter beyond frame buffer");

endmodule

[src/swsfd_queue.sv]
// Two-entry event queue between the decoder and the output stage.
module swsfd_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_nonempty,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);
    localparam int DEPTH = 2;
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full     = r_count == CW'(DEPTH);
    assign o_nonempty = r_count != '0;
    assign o_data     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |-> !i_push)
        else $error("push into a full queue");

endmodule

[src/swsfd_back.sv]
// Output stage: checksum check, field formatting and the result register.
module swsfd_back #(
    parameter int FRAME_BYTES = swsfd_pkg::FRAME_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_nonempty,
    output logic                              o_q_pop,
    input  swsfd_pkg::t_event                 i_event,
    input  logic [FRAME_BYTES*8-1:0]          i_bits,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [swsfd_pkg::STATUS_W-1:0]    o_status,
    output logic [swsfd_pkg::BYTE_W-1:0]      o_humidity_whole,
    output logic [swsfd_pkg::BYTE_W-1:0]      o_humidity_fraction,
    output logic [swsfd_pkg::BYTE_W-1:0]      o_temperature_whole,
    output logic [swsfd_pkg::BYTE_W-1:0]      o_temperature_fraction,
    output logic [swsfd_pkg::BYTE_W-1:0]      o_checksum_byte
);
    import swsfd_pkg::*;

    logic                r_valid;
    logic [STATUS_W-1:0] r_status;
    logic [BYTE_W-1:0]   r_data [4];
    logic [BYTE_W-1:0]   r_chk;

    logic [BYTE_W-1:0]   sum;
    logic [BYTE_W-1:0]   chk;
    logic [BYTE_W-1:0]   data [4];
    logic [STATUS_W-1:0] status;

    assign chk = i_bits[(FRAME_BYTES-1)*8 +: 8];

    always_comb begin
        sum = '0;
        for (int k = 0; k < FRAME_BYTES - 1; k++) begin
            sum = sum + i_bits[k*8 +: 8];
        end
    end

    // Data fields for bytes that belong to the checksum position or beyond read as zero.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            data[k] = '0;
            if (k < FRAME_BYTES - 1) begin
                data[k] = i_bits[k*8 +: 8];
            end
        end
    end

    assign status  = i_event.is_frame ? ((sum == chk) ? ST_OK : ST_MISMATCH)
                                      : i_event.err_status;
    assign o_q_pop = i_q_nonempty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_status <= status;
            r_data   <= data;
            r_chk    <= chk;
        end
    end

    assign o_valid                = r_valid;
    assign o_status               = r_status;
    assign o_humidity_whole       = r_data[0];
    assign o_humidity_fraction    = r_data[1];
    assign o_temperature_whole    = r_data[2];
    assign o_temperature_fraction = r_data[3];
    assign o_checksum_byte        = r_chk;

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_valid)
        else $error("result register empty after a queue pop");

endmodule
